/* rtl/core/node_alias_lru_cache_top_assert.svh */
// Assertion macros for the alias cache top level.
`ifndef NODE_ALIAS_LRU_CACHE_TOP_ASSERT_SVH
`define NODE_ALIAS_LRU_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define NALC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define NALC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/nalc_pkg.sv */
// ----------------------------------------------------------------------------
// nalc_pkg
// Shared types, constants and the alias fold for the node alias cache.
// ----------------------------------------------------------------------------
`default_nettype none

package nalc_pkg;

    localparam int ID_W              = 48;
    localparam int AL_W              = 12;
    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int MAX_TRIES_DEF     = 64;
    localparam int LCG_SHIFT         = 9;
    localparam logic [ID_W-1:0] LCG_ADD = 48'h01B0CA37ABA9;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_REM = 3'd1,
        OP_LKI = 3'd2,
        OP_LKA = 3'd3,
        OP_GEN = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZERO   = 2'd1,
        ST_GIVEUP = 2'd2
    } t_status;

    typedef struct packed {
        logic            load;
        logic            step;
        logic [ID_W-1:0] seed;
    } t_gen_ctrl;

    // fold the 48-bit seed into a 12-bit alias
    function automatic logic [AL_W-1:0] fold_alias(input logic [ID_W-1:0] s);
        fold_alias = s[11:0] ^ s[23:12] ^ s[35:24] ^ s[47:36];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nalc_in_if.sv */
// ----------------------------------------------------------------------------
// nalc_in_if
// Command channel: opcode and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nalc_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                opcode;
    logic [nalc_pkg::ID_W-1:0] node_id;
    logic [nalc_pkg::AL_W-1:0] node_alias;

    modport source (output valid, output opcode, output node_id, output node_alias,
                    input ready);
    modport sink   (input valid, input opcode, input node_id, input node_alias,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/nalc_out_if.sv */
// ----------------------------------------------------------------------------
// nalc_out_if
// Result channel: status, lookup results and drop report.
// ----------------------------------------------------------------------------
`default_nettype none

interface nalc_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic                      hit;
    logic [nalc_pkg::ID_W-1:0] found_id;
    logic [nalc_pkg::AL_W-1:0] found_alias;
    logic                      dropped;
    logic [nalc_pkg::ID_W-1:0] dropped_id;
    logic [nalc_pkg::AL_W-1:0] dropped_alias;

    modport source (output valid, output status, output hit, output found_id,
                    output found_alias, output dropped, output dropped_id,
                    output dropped_alias, input ready);
    modport sink   (input valid, input status, input hit, input found_id,
                    input found_alias, input dropped, input dropped_id,
                    input dropped_alias, output ready);
endinterface

`default_nettype wire

/* rtl/core/nalc_ram.sv */
// ----------------------------------------------------------------------------
// nalc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nalc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nalc_gen.sv */
// ----------------------------------------------------------------------------
// nalc_gen
// Alias generator: 48-bit LCG seed register and 12-bit fold.
// ----------------------------------------------------------------------------
`default_nettype none

module nalc_gen (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire nalc_pkg::t_gen_ctrl       i_ctrl,
    output logic [nalc_pkg::AL_W-1:0]      o_alias
);

    logic [nalc_pkg::ID_W-1:0] r_seed;
    logic [nalc_pkg::ID_W-1:0] n_seed;

    // s * 513 + c, as shift and add
    assign n_seed  = (r_seed << nalc_pkg::LCG_SHIFT) + r_seed + nalc_pkg::LCG_ADD;
    assign o_alias = nalc_pkg::fold_alias(r_seed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_ctrl.load) begin
            r_seed <= i_ctrl.seed;
        end else if (i_ctrl.step) begin
            r_seed <= n_seed;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/node_alias_lru_cache_top.sv */
// Sequence: a hit on lookup or remove and every add run the search sweep, decide, the age
// update sweep and the result; a miss skips the update sweep, and a zero operand or an
// unused opcode goes straight to the result. One item is worked at a time; the next can be
// taken in the cycle after its result is registered. Generate: a zero alias uses one try,
// a colliding try a search sweep and a touch sweep; it gives up after MAX_TRIES tries.
// Reset (synchronous) clears the valid flags at once: no clearing pass; the seed returns to 0.
// ----------------------------------------------------------------------------
// node_alias_lru_cache_top
// LRU cache of node id / alias pairs held in one RAM, searched by sweeps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "node_alias_lru_cache_top_assert.svh"

module node_alias_lru_cache_top #(
    parameter int CACHE_ENTRIES = nalc_pkg::CACHE_ENTRIES_DEF,
    parameter int MAX_TRIES     = nalc_pkg::MAX_TRIES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [nalc_pkg::ID_W-1:0] i_cfg_wdata,
    nalc_in_if.sink                        i_in,
    nalc_out_if.source                     o_out
);

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int TW = $clog2(MAX_TRIES + 1);
    localparam int ID_W = nalc_pkg::ID_W;
    localparam int AL_W = nalc_pkg::AL_W;
    localparam int DW = ID_W + AL_W + IW;
    localparam logic [IW-1:0] LAST = IW'(CACHE_ENTRIES - 1);
    localparam logic [TW-1:0] TRY_LAST = TW'(MAX_TRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_UPD, S_GEN, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        M_FREE, M_TOUCH, M_ADD
    } t_mode;

    t_state                 r_state;
    nalc_pkg::t_op          r_op;
    logic [ID_W-1:0]        r_id;
    logic [AL_W-1:0]        r_key;
    logic [CACHE_ENTRIES-1:0] r_used;
    logic [CACHE_ENTRIES-1:0] r_live;

    // sweep pointers
    logic [IW-1:0]          r_idx;
    logic                   r_issue;
    logic                   r_pv;
    logic [IW-1:0]          r_pidx;

    // search results
    logic                   r_fa_found;
    logic [IW-1:0]          r_fa_idx;
    logic [IW-1:0]          r_fa_age;
    logic [ID_W-1:0]        r_fa_id;
    logic                   r_fi_found;
    logic [IW-1:0]          r_fi_idx;
    logic [IW-1:0]          r_fi_age;
    logic [AL_W-1:0]        r_fi_alias;
    logic                   r_old_found;
    logic [IW-1:0]          r_old_idx;
    logic [IW-1:0]          r_old_age;
    logic [ID_W-1:0]        r_old_id;
    logic [AL_W-1:0]        r_old_alias;
    logic                   r_free_found;
    logic [IW-1:0]          r_free_idx;

    // update sweep control
    t_mode                  r_mode;
    logic [IW-1:0]          r_tgt;
    logic [IW-1:0]          r_rank;
    logic                   r_dec;
    logic [IW-1:0]          r_slot;
    logic [TW-1:0]          r_tries;

    // result under construction
    nalc_pkg::t_status      r_status;
    logic                   r_hit;
    logic [ID_W-1:0]        r_fid;
    logic [AL_W-1:0]        r_fal;
    logic                   r_drop;
    logic [ID_W-1:0]        r_did;
    logic [AL_W-1:0]        r_dal;

    // output register
    logic                   r_out_valid;
    nalc_pkg::t_status      r_q_status;
    logic                   r_q_hit;
    logic [ID_W-1:0]        r_q_fid;
    logic [AL_W-1:0]        r_q_fal;
    logic                   r_q_drop;
    logic [ID_W-1:0]        r_q_did;
    logic [AL_W-1:0]        r_q_dal;

    // RAM and generator wiring
    logic [DW-1:0]          rd_data;
    logic [DW-1:0]          wr_data;
    logic                   wr_en;
    logic [ID_W-1:0]        rd_id;
    logic [AL_W-1:0]        rd_al;
    logic [IW-1:0]          rd_age;
    logic [IW-1:0]          new_age;
    logic [AL_W-1:0]        gen_alias;
    nalc_pkg::t_gen_ctrl    gctrl;
    logic                   sw_done;
    logic                   in_acc;
    nalc_pkg::t_op          in_op;

    // add decision
    logic                   add_drop;
    logic [IW-1:0]          add_d;
    logic [IW-1:0]          add_rank;
    logic [IW-1:0]          add_slot;
    logic [ID_W-1:0]        add_did;
    logic [AL_W-1:0]        add_dal;

    assign rd_id  = rd_data[ID_W-1:0];
    assign rd_al  = rd_data[ID_W +: AL_W];
    assign rd_age = rd_data[ID_W+AL_W +: IW];

    assign sw_done = r_pv && (r_pidx == LAST);
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc = i_in.valid && i_in.ready;
    assign in_op = nalc_pkg::t_op'(i_in.opcode);

    assign gctrl.load = i_cfg_we;
    assign gctrl.step = (r_state == S_GEN);
    assign gctrl.seed = i_cfg_wdata;

    nalc_ram #(
        .WIDTH (DW),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_pidx),
        .i_wdata (wr_data),
        .i_re    (r_issue),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    nalc_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (gctrl),
        .o_alias (gen_alias)
    );

    // pick the slot and the mapping an add drops
    always_comb begin
        add_drop = 1'b1;
        add_d    = r_old_idx;
        add_rank = r_old_age;
        add_slot = r_old_idx;
        add_did  = r_old_id;
        add_dal  = r_old_alias;
        if (r_fa_found) begin
            add_d    = r_fa_idx;
            add_rank = r_fa_age;
            add_did  = r_fa_id;
            add_dal  = r_key;
            add_slot = (r_free_found && (r_free_idx < r_fa_idx)) ? r_free_idx : r_fa_idx;
        end else if (r_free_found) begin
            add_drop = 1'b0;
            add_slot = r_free_idx;
        end
    end

    // age rewrite during the update sweep
    always_comb begin
        wr_en   = 1'b0;
        new_age = rd_age;
        wr_data = {rd_age, rd_al, rd_id};
        if ((r_state == S_UPD) && r_pv) begin
            case (r_mode)
                M_FREE: begin
                    if (r_used[r_pidx] && (rd_age > r_rank)) begin
                        wr_en   = 1'b1;
                        new_age = rd_age - IW'(1);
                    end
                end
                M_TOUCH: begin
                    if (r_pidx == r_tgt) begin
                        wr_en   = 1'b1;
                        new_age = '0;
                    end else if (r_used[r_pidx] && (rd_age < r_rank)) begin
                        wr_en   = 1'b1;
                        new_age = rd_age + IW'(1);
                    end
                end
                M_ADD: begin
                    if (r_pidx == r_slot) begin
                        wr_en   = 1'b1;
                        new_age = '0;
                    end else if (r_used[r_pidx]) begin
                        wr_en = 1'b1;
                        if (!(r_dec && (rd_age > r_rank))) begin
                            new_age = rd_age + IW'(1);
                        end
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
            if ((r_mode == M_ADD) && (r_pidx == r_slot)) begin
                wr_data = {new_age, r_key, r_id};
            end else begin
                wr_data = {new_age, rd_al, rd_id};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_live      <= '0;
            r_issue     <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // sweep pointer: issue one read a cycle, data follows in the next cycle
            if ((r_state == S_SCAN) || (r_state == S_UPD)) begin
                r_pv   <= r_issue;
                r_pidx <= r_idx;
                if (r_issue) begin
                    if (r_idx == LAST) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op       <= in_op;
                        r_id       <= i_in.node_id;
                        r_key      <= i_in.node_alias;
                        r_status   <= nalc_pkg::ST_OK;
                        r_hit      <= 1'b0;
                        r_fid      <= '0;
                        r_fal      <= '0;
                        r_drop     <= 1'b0;
                        r_did      <= '0;
                        r_dal      <= '0;
                        r_tries    <= '0;
                        r_idx      <= '0;
                        r_fa_found <= 1'b0;
                        r_fi_found <= 1'b0;
                        r_old_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        case (in_op)
                            nalc_pkg::OP_ADD: begin
                                if ((i_in.node_id == '0) || (i_in.node_alias == '0)) begin
                                    r_status <= nalc_pkg::ST_ZERO;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            nalc_pkg::OP_REM, nalc_pkg::OP_LKA: begin
                                if (i_in.node_alias == '0) begin
                                    r_status <= nalc_pkg::ST_ZERO;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            nalc_pkg::OP_LKI: begin
                                if (i_in.node_id == '0) begin
                                    r_status <= nalc_pkg::ST_ZERO;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            nalc_pkg::OP_GEN: begin
                                r_state <= S_GEN;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end

                S_GEN: begin
                    // one try per visit; the seed advances this cycle
                    if (gen_alias == '0) begin
                        if (r_tries == TRY_LAST) begin
                            r_status <= nalc_pkg::ST_GIVEUP;
                            r_state  <= S_RESP;
                        end else begin
                            r_tries <= r_tries + TW'(1);
                        end
                    end else begin
                        r_key        <= gen_alias;
                        r_idx        <= '0;
                        r_issue      <= 1'b1;
                        r_fa_found   <= 1'b0;
                        r_fi_found   <= 1'b0;
                        r_old_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (r_pv) begin
                        if (r_used[r_pidx] && (rd_al == r_key) && !r_fa_found) begin
                            r_fa_found <= 1'b1;
                            r_fa_idx   <= r_pidx;
                            r_fa_age   <= rd_age;
                            r_fa_id    <= rd_id;
                        end
                        if (r_used[r_pidx] && r_live[r_pidx] && (rd_id == r_id)
                                && !r_fi_found) begin
                            r_fi_found <= 1'b1;
                            r_fi_idx   <= r_pidx;
                            r_fi_age   <= rd_age;
                            r_fi_alias <= rd_al;
                        end
                        if (r_used[r_pidx] && (!r_old_found || (rd_age > r_old_age))) begin
                            r_old_found <= 1'b1;
                            r_old_idx   <= r_pidx;
                            r_old_age   <= rd_age;
                            r_old_id    <= rd_id;
                            r_old_alias <= rd_al;
                        end
                        if (!r_used[r_pidx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pidx;
                        end
                    end
                    if (sw_done) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    r_idx   <= '0;
                    r_state <= S_RESP;
                    case (r_op)
                        nalc_pkg::OP_ADD: begin
                            r_drop <= add_drop;
                            if (add_drop) begin
                                r_did <= add_did;
                                r_dal <= add_dal;
                                r_used[add_d] <= 1'b0;
                                r_live[add_d] <= 1'b0;
                            end
                            if (r_fi_found) begin
                                r_live[r_fi_idx] <= 1'b0;
                            end
                            r_used[add_slot] <= 1'b1;
                            r_live[add_slot] <= 1'b1;
                            r_mode  <= M_ADD;
                            r_dec   <= add_drop;
                            r_rank  <= add_rank;
                            r_slot  <= add_slot;
                            r_issue <= 1'b1;
                            r_state <= S_UPD;
                        end
                        nalc_pkg::OP_REM: begin
                            if (r_fa_found) begin
                                r_hit  <= 1'b1;
                                r_used[r_fa_idx] <= 1'b0;
                                r_live[r_fa_idx] <= 1'b0;
                                r_mode  <= M_FREE;
                                r_rank  <= r_fa_age;
                                r_issue <= 1'b1;
                                r_state <= S_UPD;
                            end
                        end
                        nalc_pkg::OP_LKI: begin
                            if (r_fi_found) begin
                                r_hit   <= 1'b1;
                                r_fal   <= r_fi_alias;
                                r_mode  <= M_TOUCH;
                                r_tgt   <= r_fi_idx;
                                r_rank  <= r_fi_age;
                                r_issue <= 1'b1;
                                r_state <= S_UPD;
                            end
                        end
                        nalc_pkg::OP_LKA: begin
                            if (r_fa_found) begin
                                r_hit   <= 1'b1;
                                r_fid   <= r_fa_id;
                                r_mode  <= M_TOUCH;
                                r_tgt   <= r_fa_idx;
                                r_rank  <= r_fa_age;
                                r_issue <= 1'b1;
                                r_state <= S_UPD;
                            end
                        end
                        nalc_pkg::OP_GEN: begin
                            if (r_fa_found) begin
                                // collision: touch the cached entry, then retry
                                r_mode  <= M_TOUCH;
                                r_tgt   <= r_fa_idx;
                                r_rank  <= r_fa_age;
                                r_issue <= 1'b1;
                                r_state <= S_UPD;
                            end else begin
                                r_fal <= r_key;
                            end
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end

                S_UPD: begin
                    if (sw_done) begin
                        if (r_op == nalc_pkg::OP_GEN) begin
                            if (r_tries == TRY_LAST) begin
                                r_status <= nalc_pkg::ST_GIVEUP;
                                r_state  <= S_RESP;
                            end else begin
                                r_tries <= r_tries + TW'(1);
                                r_state <= S_GEN;
                            end
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end

                S_RESP: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_q_status  <= r_status;
                        r_q_hit     <= r_hit;
                        r_q_fid     <= r_fid;
                        r_q_fal     <= r_fal;
                        r_q_drop    <= r_drop;
                        r_q_did     <= r_did;
                        r_q_dal     <= r_dal;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_q_status;
    assign o_out.hit           = r_q_hit;
    assign o_out.found_id      = r_q_fid;
    assign o_out.found_alias   = r_q_fal;
    assign o_out.dropped       = r_q_drop;
    assign o_out.dropped_id    = r_q_did;
    assign o_out.dropped_alias = r_q_dal;

    `NALC_ASSERT_NOW(a_live_used, i_clk, i_rst_n, 1'b1, ((r_live & ~r_used) == '0),
        "live entry not in use")
    `NALC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_acc, !i_in.ready,
        "second item taken while busy")
    `NALC_ASSERT_NOW(a_touch_used, i_clk, i_rst_n,
        ((r_state == S_UPD) && (r_mode == M_TOUCH)), r_used[r_tgt],
        "touch target not in use")

endmodule

`default_nettype wire

/* dv/node_alias_lru_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_alias_lru_cache_checker
// Watches the command and result channels of the alias cache. It keeps its
// own copy of the cache and the generator seed, works out the result of each
// accepted command and compares it field by field with the result beats.
// ----------------------------------------------------------------------------
module node_alias_lru_cache_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nalc_pkg::ID_W-1:0] i_cfg_wdata,
    nalc_in_if                        i_in,
    nalc_out_if                       i_out,
    output int                        o_fail_count,
    output int                        o_pending
);
    localparam int ID_W  = nalc_pkg::ID_W;
    localparam int AL_W  = nalc_pkg::AL_W;
    localparam int NENT  = nalc_pkg::CACHE_ENTRIES_DEF;
    localparam int TRIES = nalc_pkg::MAX_TRIES_DEF;

    typedef struct packed {
        logic [1:0]      status;
        logic            hit;
        logic [ID_W-1:0] found_id;
        logic [AL_W-1:0] found_alias;
        logic            dropped;
        logic [ID_W-1:0] dropped_id;
        logic [AL_W-1:0] dropped_alias;
    } t_answer;

    logic [ID_W-1:0] slot_id    [NENT];
    logic [AL_W-1:0] slot_alias [NENT];
    logic            slot_used  [NENT];
    logic            slot_live  [NENT];
    int              slot_rank  [NENT];
    logic [ID_W-1:0] seed_q;
    t_answer         answers_q[$];

    int fail_count;
    assign o_fail_count = fail_count;
    assign o_pending    = answers_q.size();

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                   input logic [ID_W-1:0] want);
        $display("%0t: result %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int find_alias(input logic [AL_W-1:0] a);
        for (int i = 0; i < NENT; i++)
            if (slot_used[i] && slot_alias[i] == a) return i;
        return -1;
    endfunction

    function automatic int find_id(input logic [ID_W-1:0] id);
        for (int i = 0; i < NENT; i++)
            if (slot_used[i] && slot_live[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void make_newest(input int e);
        int r;
        r = slot_rank[e];
        for (int i = 0; i < NENT; i++)
            if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
        slot_rank[e] = 0;
    endfunction

    function automatic void release_slot(input int e);
        int r;
        r = slot_rank[e];
        slot_used[e] = 0;
        slot_live[e] = 0;
        for (int i = 0; i < NENT; i++)
            if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
        slot_rank[e] = 0;
    endfunction

    function automatic t_answer cache_step(input logic [2:0] op, input logic [ID_W-1:0] id,
                                           input logic [AL_W-1:0] al);
        t_answer         ans;
        int              e;
        int              slot;
        int              old;
        logic            ok;
        logic [ID_W-1:0] s;
        logic [AL_W-1:0] a;
        ans = '0;
        case (op)
            nalc_pkg::OP_ADD: begin
                if (id == 0 || al == 0) begin
                    ans.status = nalc_pkg::ST_ZERO;
                end else begin
                    slot = -1;
                    e = find_alias(al);
                    if (e >= 0) begin
                        ans.dropped = 1;
                        ans.dropped_id = slot_id[e];
                        ans.dropped_alias = slot_alias[e];
                        release_slot(e);
                    end
                    for (int i = 0; i < NENT; i++)
                        if (slot < 0 && !slot_used[i]) slot = i;
                    if (slot < 0) begin
                        old = 0;
                        for (int i = 1; i < NENT; i++)
                            if (slot_rank[i] > slot_rank[old]) old = i;
                        ans.dropped = 1;
                        ans.dropped_id = slot_id[old];
                        ans.dropped_alias = slot_alias[old];
                        release_slot(old);
                        slot = old;
                    end
                    e = find_id(id);
                    if (e >= 0) slot_live[e] = 0;
                    for (int i = 0; i < NENT; i++)
                        if (slot_used[i]) slot_rank[i]++;
                    slot_used[slot]  = 1;
                    slot_live[slot]  = 1;
                    slot_id[slot]    = id;
                    slot_alias[slot] = al;
                    slot_rank[slot]  = 0;
                end
            end
            nalc_pkg::OP_REM: begin
                if (al == 0) ans.status = nalc_pkg::ST_ZERO;
                else begin
                    e = find_alias(al);
                    if (e >= 0) begin
                        ans.hit = 1;
                        release_slot(e);
                    end
                end
            end
            nalc_pkg::OP_LKI: begin
                if (id == 0) ans.status = nalc_pkg::ST_ZERO;
                else begin
                    e = find_id(id);
                    if (e >= 0) begin
                        ans.hit = 1;
                        ans.found_alias = slot_alias[e];
                        make_newest(e);
                    end
                end
            end
            nalc_pkg::OP_LKA: begin
                if (al == 0) ans.status = nalc_pkg::ST_ZERO;
                else begin
                    e = find_alias(al);
                    if (e >= 0) begin
                        ans.hit = 1;
                        ans.found_id = slot_id[e];
                        make_newest(e);
                    end
                end
            end
            nalc_pkg::OP_GEN: begin
                ok = 0;
                for (int t = 0; t < TRIES && !ok; t++) begin
                    s = seed_q;
                    a = s[11:0] ^ s[23:12] ^ s[35:24] ^ s[47:36];
                    seed_q = (s << nalc_pkg::LCG_SHIFT) + s + nalc_pkg::LCG_ADD;
                    if (a != 0) begin
                        e = find_alias(a);
                        if (e >= 0) make_newest(e);
                        else begin
                            ok = 1;
                            ans.found_alias = a;
                        end
                    end
                end
                if (!ok) ans.status = nalc_pkg::ST_GIVEUP;
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < NENT; i++) begin
                slot_id[i] = '0;
                slot_alias[i] = '0;
                slot_used[i] = 0;
                slot_live[i] = 0;
                slot_rank[i] = 0;
            end
            seed_q = '0;
            answers_q.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) seed_q = i_cfg_wdata;
            if (i_in.valid && i_in.ready)
                answers_q.push_back(cache_step(i_in.opcode, i_in.node_id, i_in.node_alias));
            if (i_out.valid && i_out.ready) begin
                if (answers_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = answers_q.pop_front();
                    if (i_out.status != want.status)
                        report_mismatch("status", i_out.status, want.status);
                    if (i_out.hit != want.hit)
                        report_mismatch("hit", i_out.hit, want.hit);
                    if (i_out.found_id != want.found_id)
                        report_mismatch("found_id", i_out.found_id, want.found_id);
                    if (i_out.found_alias != want.found_alias)
                        report_mismatch("found_alias", i_out.found_alias, want.found_alias);
                    if (i_out.dropped != want.dropped)
                        report_mismatch("dropped", i_out.dropped, want.dropped);
                    if (i_out.dropped_id != want.dropped_id)
                        report_mismatch("dropped_id", i_out.dropped_id, want.dropped_id);
                    if (i_out.dropped_alias != want.dropped_alias)
                        report_mismatch("dropped_alias", i_out.dropped_alias,
                                        want.dropped_alias);
                end
            end
        end
    end
endmodule

/* dv/node_alias_lru_cache_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_alias_lru_cache_top_tb
// Drives commands into the alias cache under three idle patterns and several
// seeds; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module node_alias_lru_cache_top_tb;

    localparam int ID_W    = nalc_pkg::ID_W;
    localparam int AL_W    = nalc_pkg::AL_W;
    localparam int SWEEP   = 2 * nalc_pkg::CACHE_ENTRIES_DEF + 5;
    localparam int LIMIT   = 6000000;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            cfg_we = 0;
    logic [ID_W-1:0] cfg_wdata = '0;
    int              fail_count;
    int              pending;
    int              cycle_count = 0;
    int              src_idle_pct = 0;
    int              snk_idle_pct = 0;
    int              beats_sent = 0;

    nalc_in_if  cmd_if ();
    nalc_out_if res_if ();

    node_alias_lru_cache_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (cmd_if.sink),
        .o_out       (res_if.source)
    );

    node_alias_lru_cache_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (cmd_if),
        .i_out        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[node_alias_lru_cache_top] ERROR");
            $finish;
        end
    end

    // receiver stalls, decided on the falling edge
    initial res_if.ready = 0;
    always @(negedge i_clk)
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    initial begin
        cmd_if.valid = 0;
        cmd_if.opcode = '0;
        cmd_if.node_id = '0;
        cmd_if.node_alias = '0;
    end

    // valid stays up after a beat until the next idle cycle or the next command
    task automatic send_cmd(input logic [2:0] op, input logic [ID_W-1:0] id,
                            input logic [AL_W-1:0] al);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 0;
            @(negedge i_clk);
        end
        cmd_if.valid <= 1;
        cmd_if.opcode <= op;
        cmd_if.node_id <= id;
        cmd_if.node_alias <= al;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic drain();
        cmd_if.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * SWEEP) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [ID_W-1:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 0;
    endtask

    // pool of aliases kept small so adds collide with cached entries
    function automatic logic [AL_W-1:0] pick_alias();
        case ($urandom_range(9))
            0: return AL_W'($urandom);
            1: return '0;
            2: return '1;
            default: return AL_W'($urandom_range(24, 1));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9))
            0: return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            1: return '0;
            2: return '1;
            default: return ID_W'($urandom_range(20, 1));
        endcase
    endfunction

    task automatic random_cmds(input int count);
        int  sel;
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 40) op = nalc_pkg::OP_ADD;
            else if (sel < 52) op = nalc_pkg::OP_REM;
            else if (sel < 67) op = nalc_pkg::OP_LKI;
            else if (sel < 82) op = nalc_pkg::OP_LKA;
            else if (sel < 97) op = nalc_pkg::OP_GEN;
            else op = 3'($urandom_range(7, 5));
            send_cmd(op, pick_id(), pick_alias());
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: zero operands, extremes, full cache, eviction, repeats
        src_idle_pct = 14; snk_idle_pct = 47;
        send_cmd(nalc_pkg::OP_ADD, '0, 12'h001);
        send_cmd(nalc_pkg::OP_ADD, 48'h1, '0);
        send_cmd(nalc_pkg::OP_REM, '0, '0);
        send_cmd(nalc_pkg::OP_LKI, '0, '0);
        send_cmd(nalc_pkg::OP_LKA, '0, '0);
        send_cmd(3'd5, '1, '1);
        send_cmd(3'd7, '1, '1);
        send_cmd(nalc_pkg::OP_ADD, '1, '1);
        send_cmd(nalc_pkg::OP_LKI, '1, '0);
        send_cmd(nalc_pkg::OP_LKA, '0, '1);
        send_cmd(nalc_pkg::OP_ADD, 48'h5, '1);
        send_cmd(nalc_pkg::OP_ADD, 48'h5, 12'h2);
        send_cmd(nalc_pkg::OP_LKI, 48'h5, '0);
        send_cmd(nalc_pkg::OP_LKA, '0, '1);
        send_cmd(nalc_pkg::OP_REM, '0, '1);
        send_cmd(nalc_pkg::OP_LKI, 48'h5, '0);
        for (int i = 0; i < 18; i++)
            send_cmd(nalc_pkg::OP_ADD, ID_W'(100 + i), AL_W'(100 + i));
        send_cmd(nalc_pkg::OP_REM, '0, 12'h7FF);
        send_cmd(nalc_pkg::OP_GEN, '0, '0);
        send_cmd(nalc_pkg::OP_GEN, '0, '0);
        random_cmds(150);
        drain();

        write_seed('1);
        src_idle_pct = 47; snk_idle_pct = 14;
        random_cmds(180);
        drain();

        // restart the generator from seed 0, with no idle cycles on either side
        write_seed('0);
        src_idle_pct = 0; snk_idle_pct = 0;
        random_cmds(100);
        drain();
        write_seed({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF);
        random_cmds(100);
        drain();

        $display("sent %0d commands over four seeds and three idle patterns", beats_sent);
        if (fail_count == 0)
            $display("[node_alias_lru_cache_top] OK");
        else
            $display("[node_alias_lru_cache_top] ERROR");
        $finish;
    end
endmodule
